>>> hdl/sral_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sral_pkg
// types and constants shared by the servo load alert ramp block
// ----------------------------------------------------------------------------
package sral_pkg;

    localparam logic [11:0] CMD_MIN_US = 12'd500;
    localparam logic [11:0] CMD_MAX_US = 12'd2500;
    localparam int unsigned PERIOD_US  = 20000;

    localparam logic [11:0] RST_LOAD_HIGH  = 12'd1700;
    localparam logic [11:0] RST_LOAD_LOW   = 12'd1500;
    localparam logic [7:0]  RST_SWEEP_STEP = 8'd10;
    localparam logic [7:0]  RST_RAMP_STEP  = 8'd2;
    localparam logic [7:0]  RST_DEADBAND   = 8'd6;
    localparam logic [11:0] RST_NEUTRAL    = 12'd1500;
    localparam logic [11:0] RST_SWEEP_LOW  = 12'd500;
    localparam logic [11:0] RST_SWEEP_HIGH = 12'd2500;
    localparam logic [11:0] RST_PULSE      = 12'd1500;

    typedef enum logic [3:0] {
        CFG_LOAD_HIGH  = 4'd0,
        CFG_LOAD_LOW   = 4'd1,
        CFG_SWEEP_STEP = 4'd2,
        CFG_RAMP_STEP  = 4'd3,
        CFG_DEADBAND   = 4'd4,
        CFG_NEUTRAL    = 4'd5,
        CFG_SWEEP_LOW  = 4'd6,
        CFG_SWEEP_HIGH = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  index;
        logic [15:0] value;
    } t_cfg_write;

    typedef struct packed {
        logic [11:0] load_high_threshold;
        logic [11:0] load_low_threshold;
        logic [7:0]  sweep_step;
        logic [7:0]  ramp_step;
        logic [7:0]  deadband;
        logic [11:0] neutral_pulse;
        logic [11:0] sweep_low;
        logic [11:0] sweep_high;
    } t_cfg;

    typedef struct packed {
        logic               cmd_valid;
        logic signed [15:0] cmd_offset;
        logic               dc_running;
        logic               adc_due;
        logic [11:0]        adc_value;
    } t_in_item;

    typedef struct packed {
        logic [11:0] pulse_us;
        logic [15:0] duty;
        logic        duty_write;
        logic        high_load;
        logic [11:0] target_us;
    } t_out_item;

    typedef struct packed {
        logic [11:0] pulse;
        logic        changed;
        logic        high_load;
        logic [11:0] target;
    } t_core_state;

endpackage

>>> hdl/sral_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sral_if
// valid/ready channels for loop items, results and register writes
// ----------------------------------------------------------------------------
interface sral_in_if;
    logic              valid;
    logic              ready;
    sral_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sral_out_if;
    logic               valid;
    logic               ready;
    sral_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sral_cfg_if;
    logic                valid;
    logic                ready;
    sral_pkg::t_cfg_write data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> hdl/sral_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sral_cfg_regs
// configuration register file, one write beat per cycle
// ----------------------------------------------------------------------------
module sral_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sral_cfg_if.sink       i_cfg,
    output sral_pkg::t_cfg o_cfg
);

    sral_pkg::t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.load_high_threshold <= sral_pkg::RST_LOAD_HIGH;
            r_cfg.load_low_threshold  <= sral_pkg::RST_LOAD_LOW;
            r_cfg.sweep_step          <= sral_pkg::RST_SWEEP_STEP;
            r_cfg.ramp_step           <= sral_pkg::RST_RAMP_STEP;
            r_cfg.deadband            <= sral_pkg::RST_DEADBAND;
            r_cfg.neutral_pulse       <= sral_pkg::RST_NEUTRAL;
            r_cfg.sweep_low           <= sral_pkg::RST_SWEEP_LOW;
            r_cfg.sweep_high          <= sral_pkg::RST_SWEEP_HIGH;
        end else if (i_cfg.valid) begin
            case (sral_pkg::t_cfg_idx'(i_cfg.data.index))
                sral_pkg::CFG_LOAD_HIGH:  r_cfg.load_high_threshold <= i_cfg.data.value[11:0];
                sral_pkg::CFG_LOAD_LOW:   r_cfg.load_low_threshold  <= i_cfg.data.value[11:0];
                sral_pkg::CFG_SWEEP_STEP: r_cfg.sweep_step          <= i_cfg.data.value[7:0];
                sral_pkg::CFG_RAMP_STEP:  r_cfg.ramp_step           <= i_cfg.data.value[7:0];
                sral_pkg::CFG_DEADBAND:   r_cfg.deadband            <= i_cfg.data.value[7:0];
                sral_pkg::CFG_NEUTRAL:    r_cfg.neutral_pulse       <= i_cfg.data.value[11:0];
                sral_pkg::CFG_SWEEP_LOW:  r_cfg.sweep_low           <= i_cfg.data.value[11:0];
                sral_pkg::CFG_SWEEP_HIGH: r_cfg.sweep_high          <= i_cfg.data.value[11:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> hdl/sral_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sral_core
// per-pass update: command clamp, load hysteresis, alert sweep and ramp
// ----------------------------------------------------------------------------
module sral_core #(
    parameter int ADC_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  sral_pkg::t_in_item    i_item,
    input  sral_pkg::t_cfg        i_cfg,
    output sral_pkg::t_core_state o_state
);

    localparam logic [11:0] ADC_MASK = 12'((64'd1 << ADC_BITS) - 64'd1);

    logic [11:0] r_target, n_target;
    logic [11:0] r_pulse, n_pulse;
    logic        r_flag, n_flag;
    logic        r_rising, n_rising;
    logic        r_changed, n_changed;

    logic signed [17:0] w_sum;
    logic [11:0]        w_clamp;
    logic signed [12:0] w_dist;
    logic [12:0]        w_abs;
    logic [11:0]        w_tgt_cmd;
    logic [11:0]        w_adc;
    logic               w_sample;
    logic [12:0]        w_up;
    logic signed [13:0] w_dn;
    logic [12:0]        w_rup;
    logic signed [13:0] w_rdn;

    always_comb begin
        w_sum = $signed({6'b0, i_cfg.neutral_pulse})
              + $signed({{2{i_item.cmd_offset[15]}}, i_item.cmd_offset});
        if (w_sum < $signed({6'b0, sral_pkg::CMD_MIN_US})) begin
            w_clamp = sral_pkg::CMD_MIN_US;
        end else if (w_sum > $signed({6'b0, sral_pkg::CMD_MAX_US})) begin
            w_clamp = sral_pkg::CMD_MAX_US;
        end else begin
            w_clamp = w_sum[11:0];
        end
        w_dist = $signed({1'b0, w_clamp}) - $signed({1'b0, i_cfg.neutral_pulse});
        w_abs  = w_dist[12] ? 13'(-w_dist) : 13'(w_dist);

        if (!i_item.cmd_valid) begin
            w_tgt_cmd = r_target;
        end else if (w_abs <= {5'b0, i_cfg.deadband}) begin
            w_tgt_cmd = i_cfg.neutral_pulse;
        end else begin
            w_tgt_cmd = w_clamp;
        end
    end

    // load hysteresis, set wins
    always_comb begin
        w_adc    = i_item.adc_value & ADC_MASK;
        w_sample = i_item.dc_running && i_item.adc_due;
        n_flag   = r_flag;
        if (w_sample) begin
            if (w_adc > i_cfg.load_high_threshold) begin
                n_flag = 1'b1;
            end else if (w_adc < i_cfg.load_low_threshold) begin
                n_flag = 1'b0;
            end
        end
    end

    // alert sweep between bounds
    always_comb begin
        w_up     = {1'b0, w_tgt_cmd} + {5'b0, i_cfg.sweep_step};
        w_dn     = $signed({2'b0, w_tgt_cmd}) - $signed({6'b0, i_cfg.sweep_step});
        n_target = w_tgt_cmd;
        n_rising = r_rising;
        if (w_sample && n_flag) begin
            if (r_rising) begin
                if (w_up >= {1'b0, i_cfg.sweep_high}) begin
                    n_target = i_cfg.sweep_high;
                    n_rising = 1'b0;
                end else begin
                    n_target = w_up[11:0];
                end
            end else begin
                if (w_dn <= $signed({2'b0, i_cfg.sweep_low})) begin
                    n_target = i_cfg.sweep_low;
                    n_rising = 1'b1;
                end else begin
                    n_target = w_dn[11:0];
                end
            end
        end
    end

    // ramp toward target
    always_comb begin
        w_rup   = {1'b0, r_pulse} + {5'b0, i_cfg.ramp_step};
        w_rdn   = $signed({2'b0, r_pulse}) - $signed({6'b0, i_cfg.ramp_step});
        n_pulse = r_pulse;
        if (r_pulse < n_target) begin
            n_pulse = (w_rup < {1'b0, n_target}) ? w_rup[11:0] : n_target;
        end else if (r_pulse > n_target) begin
            n_pulse = (w_rdn > $signed({2'b0, n_target})) ? w_rdn[11:0] : n_target;
        end
        n_changed = (n_pulse != r_pulse);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target  <= sral_pkg::RST_PULSE;
            r_pulse   <= sral_pkg::RST_PULSE;
            r_flag    <= 1'b0;
            r_rising  <= 1'b1;
            r_changed <= 1'b0;
        end else if (i_load) begin
            r_target  <= n_target;
            r_pulse   <= n_pulse;
            r_flag    <= n_flag;
            r_rising  <= n_rising;
            r_changed <= n_changed;
        end
    end

    assign o_state.pulse     = r_pulse;
    assign o_state.changed   = r_changed;
    assign o_state.high_load = r_flag;
    assign o_state.target    = r_target;

endmodule

>>> hdl/sral_duty.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sral_duty
// duty word pulse*(2^PWM_BITS-1)/20000 over two register stages
// ----------------------------------------------------------------------------
module sral_duty #(
    parameter int PWM_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_ld_x,
    input  logic        i_ld_q,
    input  logic [11:0] i_pulse,
    output logic [15:0] o_duty
);

    localparam int          XW    = 12 + PWM_BITS;
    localparam int          SH    = XW + 15;
    localparam int          MW    = XW + 1;
    localparam int          PW    = 2 * XW + 1;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(sral_pkg::PERIOD_US) - 64'd1)
                                  / 64'(sral_pkg::PERIOD_US);

    logic [XW-1:0] r_x, n_x;
    logic [PW-1:0] w_prod;
    logic [15:0]   r_q, n_q;

    // pulse times full scale as shift and subtract
    assign n_x = (XW'(i_pulse) << PWM_BITS) - XW'(i_pulse);

    // exact floor division by the period through a rounded-up reciprocal
    assign w_prod = PW'(r_x) * PW'(RECIP[MW-1:0]);
    assign n_q    = 16'(w_prod[PW-1:SH]);

    always_ff @(posedge i_clk) begin
        if (i_ld_x) begin
            r_x <= n_x;
        end
        if (i_ld_q) begin
            r_q <= n_q;
        end
    end

    assign o_duty = r_q;

endmodule

>>> hdl/servo_load_alert_ramp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_load_alert_ramp_top
// servo target with load alert sweep, pulse ramp and pwm duty word
// ----------------------------------------------------------------------------
// path: an accepted item beat passes the input, core, duty product and output registers to its result beat
// throughput: one item per cycle while results are taken; the core updates its state on each accepted item
// stalls: the four-stage pipe keeps taking items while its later stages have room
// reset: synchronous, restores register defaults and loop state, empties the pipe
// ----------------------------------------------------------------------------
module servo_load_alert_ramp_top #(
    parameter int PWM_BITS = 16,
    parameter int ADC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sral_in_if.sink     i_item,
    sral_out_if.source  o_result,
    sral_cfg_if.sink    i_cfg
);

    logic [3:0]            r_vld, n_vld;
    logic [3:0]            w_ld;
    sral_pkg::t_in_item    r_in;
    sral_pkg::t_cfg        w_cfg;
    sral_pkg::t_core_state w_core;
    sral_pkg::t_core_state r_s2;
    sral_pkg::t_core_state r_s3;
    logic [15:0]           w_duty;

    // stage loads ripple back from the output
    always_comb begin
        w_ld[3] = !r_vld[3] || o_result.ready;
        w_ld[2] = !r_vld[2] || w_ld[3];
        w_ld[1] = !r_vld[1] || w_ld[2];
        w_ld[0] = !r_vld[0] || w_ld[1];
        n_vld[0] = w_ld[0] ? i_item.valid : r_vld[0];
        n_vld[1] = w_ld[1] ? r_vld[0] : r_vld[1];
        n_vld[2] = w_ld[2] ? r_vld[1] : r_vld[2];
        n_vld[3] = w_ld[3] ? r_vld[2] : r_vld[3];
    end

    assign i_item.ready = w_ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 4'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0] && i_item.valid) begin
            r_in <= i_item.data;
        end
        if (w_ld[2] && r_vld[1]) begin
            r_s2 <= w_core;
        end
        if (w_ld[3] && r_vld[2]) begin
            r_s3 <= r_s2;
        end
    end

    sral_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    sral_core #(
        .ADC_BITS (ADC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_ld[1] && r_vld[0]),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_state (w_core)
    );

    sral_duty #(
        .PWM_BITS (PWM_BITS)
    ) u_duty (
        .i_clk   (i_clk),
        .i_ld_x  (w_ld[2] && r_vld[1]),
        .i_ld_q  (w_ld[3] && r_vld[2]),
        .i_pulse (w_core.pulse),
        .o_duty  (w_duty)
    );

    assign o_result.valid           = r_vld[3];
    assign o_result.data.pulse_us   = r_s3.pulse;
    assign o_result.data.duty       = w_duty;
    assign o_result.data.duty_write = r_s3.changed;
    assign o_result.data.high_load  = r_s3.high_load;
    assign o_result.data.target_us  = r_s3.target;

    // the load flag only moves on a beat that carries a current sample
    a_flag_needs_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld[1] && r_vld[0] && !(r_in.dc_running && r_in.adc_due))
            |=> $stable(w_core.high_load))
        else $error("load flag moved without a sample");

    // write flag marks exactly a pulse change
    a_changed_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ld[1] && r_vld[0]) |=> (w_core.changed == (w_core.pulse != $past(w_core.pulse))))
        else $error("duty write flag does not match pulse change");

    // an empty output stage leaves room all the way back
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[3] |-> i_item.ready)
        else $error("input stalled with empty output stage");

endmodule

>>> sim/sral_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sral_check
// Watches the loop item, result and register write channels of the servo
// load alert ramp block. Keeps its own copy of the registers and loop state,
// works out the result of every accepted loop pass and compares each result
// beat with the oldest outstanding one. Hands the mismatch count and the
// number of outstanding results to the testbench top.
// ----------------------------------------------------------------------------
module sral_check #(
    parameter int PWM_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sral_in_if   i_item,
    sral_out_if  i_result,
    sral_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_pending
);

    sral_pkg::t_cfg      regs;
    int                  target_us;
    int                  ramped_us;
    int                  written_us;
    logic                load_flag;
    logic                sweep_up;
    int                  errors = 0;
    sral_pkg::t_out_item pass_results[$];

    function automatic sral_pkg::t_out_item loop_pass(input sral_pkg::t_in_item it);
        int                  cmd_us;
        int                  off_us;
        int                  stepped;
        logic                changed;
        sral_pkg::t_out_item r;
        changed = 1'b0;
        if (it.cmd_valid) begin
            cmd_us = int'(regs.neutral_pulse) + int'($signed(it.cmd_offset));
            if (cmd_us < int'(sral_pkg::CMD_MIN_US)) cmd_us = int'(sral_pkg::CMD_MIN_US);
            if (cmd_us > int'(sral_pkg::CMD_MAX_US)) cmd_us = int'(sral_pkg::CMD_MAX_US);
            off_us = cmd_us - int'(regs.neutral_pulse);
            if (off_us < 0) off_us = -off_us;
            if (off_us <= int'(regs.deadband)) cmd_us = int'(regs.neutral_pulse);
            target_us = cmd_us;
        end
        if (it.dc_running && it.adc_due) begin
            if (it.adc_value > regs.load_high_threshold) begin
                load_flag = 1'b1;
            end else if (it.adc_value < regs.load_low_threshold) begin
                load_flag = 1'b0;
            end
            if (load_flag) begin
                if (sweep_up) begin
                    target_us = target_us + int'(regs.sweep_step);
                    if (target_us >= int'(regs.sweep_high)) begin
                        target_us = int'(regs.sweep_high);
                        sweep_up  = 1'b0;
                    end
                end else begin
                    target_us = target_us - int'(regs.sweep_step);
                    if (target_us <= int'(regs.sweep_low)) begin
                        target_us = int'(regs.sweep_low);
                        sweep_up  = 1'b1;
                    end
                end
            end
        end
        if (ramped_us < target_us) begin
            stepped   = ramped_us + int'(regs.ramp_step);
            ramped_us = (stepped < target_us) ? stepped : target_us;
        end else if (ramped_us > target_us) begin
            stepped   = ramped_us - int'(regs.ramp_step);
            ramped_us = (stepped > target_us) ? stepped : target_us;
        end
        if (ramped_us != written_us) begin
            written_us = ramped_us;
            changed    = 1'b1;
        end
        r.pulse_us   = 12'(written_us);
        r.duty       = 16'((longint'(written_us) * ((longint'(1) << PWM_BITS) - 1))
                           / longint'(sral_pkg::PERIOD_US));
        r.duty_write = changed;
        r.high_load  = load_flag;
        r.target_us  = 12'(target_us);
        return r;
    endfunction

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        sral_pkg::t_out_item want;
        if (!i_rst_n) begin
            regs.load_high_threshold = sral_pkg::RST_LOAD_HIGH;
            regs.load_low_threshold  = sral_pkg::RST_LOAD_LOW;
            regs.sweep_step          = sral_pkg::RST_SWEEP_STEP;
            regs.ramp_step           = sral_pkg::RST_RAMP_STEP;
            regs.deadband            = sral_pkg::RST_DEADBAND;
            regs.neutral_pulse       = sral_pkg::RST_NEUTRAL;
            regs.sweep_low           = sral_pkg::RST_SWEEP_LOW;
            regs.sweep_high          = sral_pkg::RST_SWEEP_HIGH;
            target_us  = int'(sral_pkg::RST_PULSE);
            ramped_us  = int'(sral_pkg::RST_PULSE);
            written_us = int'(sral_pkg::RST_PULSE);
            load_flag  = 1'b0;
            sweep_up   = 1'b1;
            pass_results.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (sral_pkg::t_cfg_idx'(i_cfg.data.index))
                    sral_pkg::CFG_LOAD_HIGH: regs.load_high_threshold = i_cfg.data.value[11:0];
                    sral_pkg::CFG_LOAD_LOW: regs.load_low_threshold = i_cfg.data.value[11:0];
                    sral_pkg::CFG_SWEEP_STEP: regs.sweep_step = i_cfg.data.value[7:0];
                    sral_pkg::CFG_RAMP_STEP: regs.ramp_step = i_cfg.data.value[7:0];
                    sral_pkg::CFG_DEADBAND: regs.deadband = i_cfg.data.value[7:0];
                    sral_pkg::CFG_NEUTRAL: regs.neutral_pulse = i_cfg.data.value[11:0];
                    sral_pkg::CFG_SWEEP_LOW: regs.sweep_low = i_cfg.data.value[11:0];
                    sral_pkg::CFG_SWEEP_HIGH: regs.sweep_high = i_cfg.data.value[11:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                if (pass_results.size() == 0) begin
                    $error("result beat with nothing outstanding: pulse_us %0d",
                           i_result.data.pulse_us);
                    errors++;
                end else begin
                    want = pass_results.pop_front();
                    check_field("pulse_us", 16'(want.pulse_us), 16'(i_result.data.pulse_us));
                    check_field("duty", want.duty, i_result.data.duty);
                    check_field("duty_write", 16'(want.duty_write),
                                16'(i_result.data.duty_write));
                    check_field("high_load", 16'(want.high_load),
                                16'(i_result.data.high_load));
                    check_field("target_us", 16'(want.target_us),
                                16'(i_result.data.target_us));
                end
            end
            if (i_item.valid && i_item.ready) begin
                pass_results.push_back(loop_pass(i_item.data));
            end
        end
        o_errors  <= errors;
        o_pending <= pass_results.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the servo load alert ramp block with a directed set of loop passes
// at reset settings, then phases of random passes under floor, full-scale,
// crossed and random register settings. Loads run in bursts so the alert
// sweep reaches its bounds. Both sides stall at random; one long result
// hold-off backs up the pipe and one pause lets it drain completely.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HALF_PERIOD  = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 78;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   hold_go;
    bit   hold_done;
    int   send_gap_pct;
    int   recv_gap_pct;
    int   cur_hi;
    int   cur_lo;
    int   cur_db;

    sral_in_if  item_ch ();
    sral_out_if res_ch ();
    sral_cfg_if cfg_ch ();

    servo_load_alert_ramp_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    sral_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_ch),
        .i_result  (res_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (fail_count),
        .o_pending (pending)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 99) < recv_gap_pct) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic sral_pkg::t_in_item mk_pass(input logic cv,
                                                   input logic signed [15:0] off,
                                                   input logic dc, input logic due,
                                                   input logic [11:0] adc);
        sral_pkg::t_in_item it;
        it.cmd_valid  = cv;
        it.cmd_offset = off;
        it.dc_running = dc;
        it.adc_due    = due;
        it.adc_value  = adc;
        return it;
    endfunction

    function automatic int pick_idling();
        int pick;
        pick = $urandom_range(0, 2);
        return (pick == 0) ? 0 : ((pick == 1) ? 10 : 35);
    endfunction

    function automatic logic [15:0] wide12(input int v);
        return {4'($urandom()), 12'(v)};
    endfunction

    function automatic logic [15:0] wide8(input int v);
        return {8'($urandom()), 8'(v)};
    endfunction

    // load_mode 0 mostly keeps the current above the high threshold, 1 below the low one
    function automatic sral_pkg::t_in_item random_pass(input int load_mode);
        sral_pkg::t_in_item it;
        int                 pick;
        it.cmd_valid = ($urandom_range(0, 4) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            it.cmd_offset = 16'($urandom_range(0, 2 * cur_db + 4) - (cur_db + 2));
        end else if (pick == 4) begin
            it.cmd_offset = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else if (pick < 7) begin
            it.cmd_offset = 16'($urandom());
        end else begin
            it.cmd_offset = 16'($urandom_range(0, 2400) - 1200);
        end
        it.dc_running = ($urandom_range(0, 9) != 0);
        it.adc_due    = ($urandom_range(0, 2) != 0);
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            it.adc_value = 12'(cur_hi + $urandom_range(0, 2) - 1);
        end else if (pick == 1) begin
            it.adc_value = 12'(cur_lo + $urandom_range(0, 2) - 1);
        end else if (load_mode == 0) begin
            it.adc_value = (cur_hi >= 4095) ? 12'hFFF : 12'($urandom_range(cur_hi + 1, 4095));
        end else if (load_mode == 1) begin
            it.adc_value = (cur_lo == 0) ? 12'h000 : 12'($urandom_range(0, cur_lo - 1));
        end else begin
            it.adc_value = 12'($urandom());
        end
        return it;
    endfunction

    task automatic send_pass(input sral_pkg::t_in_item it);
        if ($urandom_range(0, 99) < send_gap_pct) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    task automatic run_passes(input int n);
        int load_mode;
        load_mode = 2;
        for (int k = 0; k < n; k++) begin
            if (k % 16 == 0) begin
                load_mode = $urandom_range(0, 3);
                if (load_mode == 3) load_mode = 0;
            end
            send_pass(random_pass(load_mode));
        end
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [3:0] idx, input logic [15:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= '{index: idx, value: v};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [15:0] hi, input logic [15:0] lo,
                              input logic [15:0] sweep_step, input logic [15:0] ramp_step,
                              input logic [15:0] db, input logic [15:0] neutral,
                              input logic [15:0] sweep_lo, input logic [15:0] sweep_hi);
        wait_drained();
        cfg_write(sral_pkg::CFG_LOAD_HIGH, hi);
        cfg_write(sral_pkg::CFG_LOAD_LOW, lo);
        cfg_write(sral_pkg::CFG_SWEEP_STEP, sweep_step);
        cfg_write(sral_pkg::CFG_RAMP_STEP, ramp_step);
        cfg_write(sral_pkg::CFG_DEADBAND, db);
        cfg_write(sral_pkg::CFG_NEUTRAL, neutral);
        cfg_write(sral_pkg::CFG_SWEEP_LOW, sweep_lo);
        cfg_write(sral_pkg::CFG_SWEEP_HIGH, sweep_hi);
        // no such register
        cfg_write(4'($urandom_range(15, int'(sral_pkg::CFG_SWEEP_HIGH) + 1)),
                  16'($urandom()));
        cfg_ch.valid <= 1'b0;
        cur_hi = int'(hi[11:0]);
        cur_lo = int'(lo[11:0]);
        cur_db = int'(db[7:0]);
        send_gap_pct = pick_idling();
        recv_gap_pct = pick_idling();
    endtask

    task automatic random_regs();
        int lo;
        int sweep_lo;
        lo       = $urandom_range(0, 3600);
        sweep_lo = $urandom_range(0, 2500);
        write_regs(wide12(lo + $urandom_range(0, 495)), wide12(lo),
                   wide8($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(1, 60)),
                   wide8($urandom_range(0, 40)), wide8($urandom_range(0, 255)),
                   wide12($urandom_range(300, 2700)), wide12(sweep_lo),
                   wide12(sweep_lo + $urandom_range(0, 1500)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        hold_go       = 1'b0;
        send_gap_pct  = 0;
        recv_gap_pct  = 0;
        cur_hi        = int'(sral_pkg::RST_LOAD_HIGH);
        cur_lo        = int'(sral_pkg::RST_LOAD_LOW);
        cur_db        = int'(sral_pkg::RST_DEADBAND);
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: deadband edges, clamps, ignored samples, hysteresis edges
        send_pass(mk_pass(1'b1, 16'sd0, 1'b0, 1'b0, 12'd0));
        send_pass(mk_pass(1'b1, 16'sd6, 1'b0, 1'b0, 12'd0));
        send_pass(mk_pass(1'b1, 16'sd7, 1'b0, 1'b0, 12'd0));
        send_pass(mk_pass(1'b1, -16'sd6, 1'b0, 1'b0, 12'd0));
        send_pass(mk_pass(1'b1, -16'sd7, 1'b0, 1'b0, 12'd0));
        send_pass(mk_pass(1'b1, 16'sh7FFF, 1'b0, 1'b0, 12'd0));
        send_pass(mk_pass(1'b1, 16'sh8000, 1'b0, 1'b0, 12'd0));
        send_pass(mk_pass(1'b0, 16'sh1234, 1'b0, 1'b1, 12'hFFF));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b0, 12'hFFF));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'd1700));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'd1701));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'd1500));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'hFFF));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'd1499));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'hFFF));
        send_pass(mk_pass(1'b1, 16'sh7FFF, 1'b1, 1'b1, 12'hFFF));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'hFFF));
        send_pass(mk_pass(1'b1, 16'sh8000, 1'b1, 1'b1, 12'hFFF));
        send_pass(mk_pass(1'b0, 16'sd0, 1'b1, 1'b1, 12'd0));
        send_pass(mk_pass(1'b1, -16'sd1, 1'b1, 1'b1, 12'hAAA));
        send_pass(mk_pass(1'b1, 16'sh5555, 1'b1, 1'b1, 12'h555));

        // everything at the floor
        write_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_passes(PHASE_ITEMS);

        // every bit set
        write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'hFFFF, 16'hFFFF);
        run_passes(PHASE_ITEMS);

        // crossed thresholds and sweep bounds; long result hold-off midway
        write_regs(16'd1000, 16'd3000, 16'd40, 16'd50, 16'd20, 16'd1500, 16'd3000,
                   16'd1000);
        run_passes(PHASE_ITEMS / 2);
        hold_go = 1'b1;
        run_passes(PHASE_ITEMS / 2);

        // zero sweep step, neutral below the clamp range; sender pause midway
        write_regs(16'd1200, 16'd900, 16'd0, 16'd255, 16'd150, 16'd400, 16'd1000,
                   16'd2000);
        run_passes(PHASE_ITEMS / 2);
        wait_drained();
        run_passes(PHASE_ITEMS / 2);

        // neutral above the clamp range, full sweep span
        write_regs(16'd1800, 16'd1600, 16'd255, 16'd7, 16'd255, 16'd2700, 16'd0, 16'd4095);
        run_passes(PHASE_ITEMS);

        repeat (4) begin
            random_regs();
            run_passes(PHASE_ITEMS);
        end

        // back to reset values, no stalls
        write_regs(16'(sral_pkg::RST_LOAD_HIGH), 16'(sral_pkg::RST_LOAD_LOW),
                   16'(sral_pkg::RST_SWEEP_STEP), 16'(sral_pkg::RST_RAMP_STEP),
                   16'(sral_pkg::RST_DEADBAND), 16'(sral_pkg::RST_NEUTRAL),
                   16'(sral_pkg::RST_SWEEP_LOW), 16'(sral_pkg::RST_SWEEP_HIGH));
        send_gap_pct = 0;
        recv_gap_pct = 0;
        run_passes(PHASE_ITEMS);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
